FILE: rtl/core/cdf_pkg.sv
// Shared types, constants and helper function of the complex decimating FIR filter.
package cdf_pkg;

   localparam int MAX_TAPS    = 128;
   localparam int SAMPLE_BITS = 16;
   localparam int COEF_BITS   = 16;
   localparam int ACC_W       = 40;
   localparam int COUNT_W     = 16;
   localparam int CFG_W       = 8;
   localparam int CMD_W       = 2;
   localparam int CIDX_W      = 7;
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 2;

   localparam int ADDR_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int TAP_W  = $clog2(MAX_TAPS + 1);
   localparam int PROD_W = SAMPLE_BITS + COEF_BITS;

   localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_COEF   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_START  = 2'd2;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_COEF   = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_TAP_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEC_STEP  = 2'd1;

   typedef struct packed {
      logic [CFG_W-1:0] tap_count;
      logic [CFG_W-1:0] decimation_step;
   } cfg_type;

   typedef struct packed {
      logic                          op;
      logic                          emit;
      logic [COUNT_W-1:0]            number;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [ADDR_W-1:0]             coef_addr;
      logic signed [COEF_BITS-1:0]   coef_real;
      logic signed [COEF_BITS-1:0]   coef_imag;
   } entry_type;

   function automatic logic [TAP_W-1:0] taps_in_use(input logic [CFG_W-1:0] tap_count);
      logic [TAP_W-1:0] taps;
      if (tap_count == '0) begin
         taps = TAP_W'(1);
      end else if (32'(tap_count) > MAX_TAPS) begin
         taps = TAP_W'(MAX_TAPS);
      end else begin
         taps = TAP_W'(tap_count);
      end
      return taps;
   endfunction

endpackage

FILE: rtl/core/cdf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module cdf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/cdf_front.sv
// Front end: accepts items, keeps the block counters and decides which pushes produce a result.
module cdf_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   input  logic                                  queue_full,
   input  logic [cdf_pkg::CMD_W-1:0]             command,
   input  logic signed [cdf_pkg::SAMPLE_BITS-1:0] sample,
   input  logic [cdf_pkg::CIDX_W-1:0]            coef_index,
   input  logic signed [cdf_pkg::COEF_BITS-1:0]  coef_real,
   input  logic signed [cdf_pkg::COEF_BITS-1:0]  coef_imag,
   input  cdf_pkg::cfg_type                      cfg,
   output logic                                  enq,
   output cdf_pkg::entry_type                    enq_entry
);
   import cdf_pkg::*;

   logic [TAP_W-1:0]   seen_ff, seen_in;
   logic [CFG_W-1:0]   phase_ff, phase_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               accept;
   logic               emit;
   logic [TAP_W-1:0]   taps;
   logic [CFG_W:0]     step;
   logic [CFG_W:0]     phase_next;

   assign accept     = push && !queue_full;
   assign taps       = taps_in_use(cfg.tap_count);
   assign step       = (cfg.decimation_step == '0) ? (CFG_W+1)'(1) : {1'b0, cfg.decimation_step};
   assign phase_next = {1'b0, phase_ff} + (CFG_W+1)'(1);

   always_comb begin
      seen_in  = seen_ff;
      phase_in = phase_ff;
      count_in = count_ff;
      emit     = 1'b0;
      enq      = 1'b0;
      if (accept) begin
         unique case (command)
            CMD_SAMPLE: begin
               enq = 1'b1;
               if (seen_ff < taps) begin
                  seen_in = seen_ff + TAP_W'(1);
                  if (seen_in == taps) begin
                     phase_in = '0;
                     emit     = 1'b1;
                  end
               end else if (phase_next >= step) begin
                  phase_in = '0;
                  emit     = 1'b1;
               end else begin
                  phase_in = phase_next[CFG_W-1:0];
               end
            end
            CMD_COEF: begin
               enq = (32'(coef_index) < MAX_TAPS);
            end
            CMD_START: begin
               seen_in  = '0;
               phase_in = '0;
               count_in = '0;
            end
            default: begin
            end
         endcase
         if (emit) begin
            count_in = count_ff + COUNT_W'(1);
         end
      end
   end

   always_comb begin
      enq_entry.op        = (command == CMD_COEF) ? OP_COEF : OP_SAMPLE;
      enq_entry.emit      = emit;
      enq_entry.number    = count_ff;
      enq_entry.sample    = sample;
      enq_entry.coef_addr = ADDR_W'(coef_index);
      enq_entry.coef_real = coef_real;
      enq_entry.coef_imag = coef_imag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= '0;
         phase_ff <= '0;
         count_ff <= '0;
      end else begin
         seen_ff  <= seen_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: rtl/core/cdf_queue.sv
// Short queue of classified items between the front end and the filter engine.
module cdf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               enq,
   input  cdf_pkg::entry_type enq_entry,
   output logic               full,
   input  logic               deq,
   output logic               valid,
   output cdf_pkg::entry_type head
);
   import cdf_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_enq;
   logic             do_deq;

   assign full   = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign valid  = (count_ff != '0);
   assign head   = slot_ff[rd_ptr_ff];
   assign do_enq = enq && !full;
   assign do_deq = deq && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_enq) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_deq) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_enq && !do_deq) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!do_enq && do_deq) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_enq) begin
         slot_ff[wr_ptr_ff] <= enq_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/core/cdf_back.sv
// Filter engine: stores samples and coefficients and runs the shared complex multiply-accumulate.
module cdf_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  cdf_pkg::cfg_type                       cfg,
   input  logic                                   q_valid,
   input  cdf_pkg::entry_type                     q_head,
   output logic                                   q_deq,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic signed [cdf_pkg::ACC_W-1:0]       rsp_out_real,
   output logic signed [cdf_pkg::ACC_W-1:0]       rsp_out_imag,
   output logic [cdf_pkg::COUNT_W-1:0]            rsp_out_number
);
   import cdf_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic [ADDR_W-1:0]        wp_ff, wp_in;
   logic [ADDR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [ADDR_W-1:0]        tap_ff, tap_in;
   logic [COUNT_W-1:0]       number_ff, number_in;
   logic                     v1_ff, v2_ff;
   logic signed [PROD_W-1:0] prod_re_ff, prod_im_ff;
   logic signed [ACC_W-1:0]  acc_re_ff, acc_re_in;
   logic signed [ACC_W-1:0]  acc_im_ff, acc_im_in;
   logic                     out_valid_ff, out_valid_in;
   logic signed [ACC_W-1:0]  out_re_ff, out_im_ff;
   logic [COUNT_W-1:0]       out_num_ff;
   logic                     load;
   logic                     start;
   logic                     sample_wr;
   logic                     coef_wr;
   logic [ADDR_W-1:0]        last_tap;
   logic [SAMPLE_BITS-1:0]   smp_rd;
   logic [2*COEF_BITS-1:0]   coef_rd;
   logic signed [SAMPLE_BITS-1:0] smp_s;
   logic signed [COEF_BITS-1:0]   cre_s, cim_s;

   assign last_tap  = ADDR_W'(taps_in_use(cfg.tap_count) - TAP_W'(1));
   assign q_deq     = (state_ff == ST_IDLE) && q_valid;
   assign sample_wr = q_deq && (q_head.op == OP_SAMPLE);
   assign coef_wr   = q_deq && (q_head.op == OP_COEF);
   assign start     = sample_wr && q_head.emit;
   assign load      = (state_ff == ST_DRAIN) && !v1_ff && !v2_ff && (!out_valid_ff || rsp_pop);

   cdf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_sample_ram (
      .clock   (clock),
      .wr_en   (sample_wr),
      .wr_addr (wp_ff),
      .wr_data (q_head.sample),
      .rd_addr (rd_ptr_ff),
      .rd_data (smp_rd)
   );

   cdf_ram #(.WIDTH(2*COEF_BITS), .DEPTH(MAX_TAPS)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr),
      .wr_addr (q_head.coef_addr),
      .wr_data ({q_head.coef_real, q_head.coef_imag}),
      .rd_addr (tap_ff),
      .rd_data (coef_rd)
   );

   assign smp_s = signed'(smp_rd);
   assign cre_s = signed'(coef_rd[2*COEF_BITS-1:COEF_BITS]);
   assign cim_s = signed'(coef_rd[COEF_BITS-1:0]);

   always_comb begin
      state_in  = state_ff;
      wp_in     = wp_ff;
      rd_ptr_in = rd_ptr_ff;
      tap_in    = tap_ff;
      number_in = number_ff;
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      if (v2_ff) begin
         acc_re_in = acc_re_ff + ACC_W'(prod_re_ff);
         acc_im_in = acc_im_ff + ACC_W'(prod_im_ff);
      end
      if (sample_wr) begin
         wp_in = (wp_ff == ADDR_W'(MAX_TAPS - 1)) ? '0 : wp_ff + ADDR_W'(1);
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in  = ST_RUN;
               rd_ptr_in = wp_ff;
               tap_in    = '0;
               number_in = q_head.number;
               acc_re_in = '0;
               acc_im_in = '0;
            end
         end
         ST_RUN: begin
            if (tap_ff == last_tap) begin
               state_in = ST_DRAIN;
            end else begin
               tap_in    = tap_ff + ADDR_W'(1);
               rd_ptr_in = (rd_ptr_ff == '0) ? ADDR_W'(MAX_TAPS - 1) : rd_ptr_ff - ADDR_W'(1);
            end
         end
         ST_DRAIN: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      tap_ff    <= tap_in;
      number_ff <= number_in;
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
      if (v1_ff) begin
         prod_re_ff <= PROD_W'(cre_s) * PROD_W'(smp_s);
         prod_im_ff <= PROD_W'(cim_s) * PROD_W'(smp_s);
      end
      if (load) begin
         out_re_ff  <= acc_re_ff;
         out_im_ff  <= acc_im_ff;
         out_num_ff <= number_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         v1_ff        <= (state_ff == ST_RUN);
         v2_ff        <= v1_ff;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_out_real   = out_re_ff;
   assign rsp_out_imag   = out_im_ff;
   assign rsp_out_number = out_num_ff;

endmodule

FILE: rtl/core/complex_decimating_fir.sv
// Top level of the complex-coefficient decimating FIR filter.
// Items enter through a queue-style port: an item is taken when req_push is high and
// req_full is low. req_command selects a sample push, a coefficient write or the start
// of a new block. Results leave through a queue-style port: the oldest result is on
// rsp_out_* while rsp_empty is low and is taken when rsp_pop is high.
// Registers tap_count and decimation_step are written over the csr_ port, which is
// always ready; write them only while the block is idle.
// Coefficient writes and pushes that produce no result are handled by the engine while idle.
// A push that produces a result runs one shared complex multiply-accumulate over the
// taps, one tap per cycle from the sample and coefficient RAMs; the engine takes no new
// item from the queue until that result is loaded into the output register. A two-entry
// queue lets the front take items while the engine is busy.
// When the receiver stalls, the finished result waits in the output register while the
// next sum is computed; the engine holds only when a second result is ready.
// Reset clears the counters, the queue and the output register and restores tap_count
// to 128 and decimation_step to 1. Coefficients are undefined until written.
module complex_decimating_fir (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic [cdf_pkg::CMD_W-1:0]              req_command,
   input  logic signed [cdf_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic [cdf_pkg::CIDX_W-1:0]             req_coef_index,
   input  logic signed [cdf_pkg::COEF_BITS-1:0]   req_coef_real,
   input  logic signed [cdf_pkg::COEF_BITS-1:0]   req_coef_imag,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic signed [cdf_pkg::ACC_W-1:0]       rsp_out_real,
   output logic signed [cdf_pkg::ACC_W-1:0]       rsp_out_imag,
   output logic [cdf_pkg::COUNT_W-1:0]            rsp_out_number,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [cdf_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [cdf_pkg::CFG_W-1:0]              csr_data
);
   import cdf_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      enq;
   entry_type enq_entry;
   logic      q_full;
   logic      q_valid;
   logic      q_deq;
   entry_type q_head;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TAP_COUNT: cfg_in.tap_count       = csr_data;
            CSR_DEC_STEP:  cfg_in.decimation_step = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tap_count       <= CFG_W'(128);
         cfg_ff.decimation_step <= CFG_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cdf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .queue_full (q_full),
      .command    (req_command),
      .sample     (req_sample),
      .coef_index (req_coef_index),
      .coef_real  (req_coef_real),
      .coef_imag  (req_coef_imag),
      .cfg        (cfg_ff),
      .enq        (enq),
      .enq_entry  (enq_entry)
   );

   cdf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .enq       (enq),
      .enq_entry (enq_entry),
      .full      (q_full),
      .deq       (q_deq),
      .valid     (q_valid),
      .head      (q_head)
   );

   cdf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_valid        (q_valid),
      .q_head         (q_head),
      .q_deq          (q_deq),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_real   (rsp_out_real),
      .rsp_out_imag   (rsp_out_imag),
      .rsp_out_number (rsp_out_number)
   );

   assign req_full = q_full;

endmodule

FILE: rtl/core/cdf_checker.sv
// Port-level assertions for the complex decimating FIR filter and their bind to the top level.
module cdf_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_full,
   input logic                                   rsp_empty,
   input logic                                   rsp_pop,
   input logic signed [cdf_pkg::ACC_W-1:0]       rsp_out_real,
   input logic signed [cdf_pkg::ACC_W-1:0]       rsp_out_imag,
   input logic [cdf_pkg::COUNT_W-1:0]            rsp_out_number,
   input logic                                   csr_ready
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("Result port not empty after reset.");

   a_reset_not_full: assert property (@(posedge clock) reset |=> !req_full)
      else $error("Input port full after reset.");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("Configuration port not ready.");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_real)
         && $stable(rsp_out_imag) && $stable(rsp_out_number)))
      else $error("Waiting result changed before it was taken.");

endmodule

bind complex_decimating_fir cdf_checker u_cdf_checker (.*);
